>>> hw/rtl/efsd_pkg.sv
// ----------------------------------------------------------------------------
// efsd_pkg
// Shared types and constants of the earliest-free-server dispatcher.
// ----------------------------------------------------------------------------
package efsd_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_ACTIVE = 2'd0;
   localparam logic [1:0] REG_OPEN   = 2'd1;
   localparam logic [1:0] REG_CUTOFF = 2'd2;

   // item kinds on req_tuser
   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_JOB     = 1'b1;

   // reset values
   localparam logic [7:0]  RESET_ACTIVE = 8'd1;
   localparam logic [16:0] RESET_OPEN   = 17'd28800;
   localparam logic [16:0] RESET_CUTOFF = 17'd61200;

   localparam logic [13:0] SECS_PER_MIN = 14'd60;
   localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;
   localparam logic [47:0] SUM_MAX      = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0] CNT_MAX      = 24'hFF_FFFF;

   // control from the sequencer to the totals unit
   typedef struct packed {
      logic        clear;
      logic        add;
      logic [31:0] wait_secs;
   } tally_ctrl_type;

endpackage

>>> hw/rtl/earliest_free_server_dispatcher.sv
// ----------------------------------------------------------------------------
// earliest_free_server_dispatcher
// Multi-server queue dispatcher, earliest-free-server rule.
// ----------------------------------------------------------------------------
// One word in, one word out. A job word (tuser = 1) goes to the active server
// whose next-free time is smallest (lowest index on a tie) unless it arrives
// after cutoff_time, in which case it is rejected with zeros and the totals
// unchanged. Free times live in a MAX_SERVERS x 32 synchronous RAM; a job
// reads the n active entries one per cycle on the single read port, n being
// the clamped server count (1..MAX_SERVERS), then computes start and wait,
// writes back the new free time and emits. A restart word (tuser = 0) sweeps
// open_time into every RAM entry one per cycle and then acknowledges. A
// rejected job goes straight to the result. After reset the same sweep loads
// 28800 into each entry with req_tready low; csr writes are taken throughout.
// One word is worked on at a time; the result sits in an output register so a
// new word can be taken while rsp waits. Jobs must come in arrival order.
// Registers may only be written while the block is idle.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatcher
   import efsd_pkg::*;
#(
   parameter int MAX_SERVERS = 128
)
(
   input  logic          clock,
   input  logic          reset,
   // config
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [16:0]   csr_wdata,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // arrival_seconds[16:0], service_minutes[24:17]
   input  logic          req_tuser,   // op
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,   // server_index[6:0], start_seconds[38:7],
                                      // wait_seconds[70:39], total_wait[118:71],
                                      // served_count[142:119]
   output logic          rsp_tuser    // accepted
);

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_CALC   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   // config registers
   logic [7:0]  active_ff;
   logic [16:0] open_ff, cutoff_ff;

   // sequencer state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;        // scan / sweep pointer
   logic [CNT_W-1:0] n_ff, n_in;            // servers in use for this job
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [16:0]      fill_ff, fill_in;
   logic             ack_ff, ack_in;        // emit a result after the sweep
   logic [16:0]      arr_ff, arr_in;
   logic [7:0]       svc_ff, svc_in;
   logic [31:0]      best_time_ff, best_time_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      start_ff, start_in;
   logic [31:0]      wait_ff, wait_in;
   logic             acc_ff, acc_in;

   // free-time RAM
   logic [31:0]      free_mem [MAX_SERVERS];
   logic [31:0]      mem_q_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [31:0]      mem_wdata;
   logic [IDX_W-1:0] mem_raddr;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_acc_ff;
   logic [6:0]  rsp_idx_ff;
   logic [31:0] rsp_start_ff, rsp_wait_ff;
   logic [47:0] rsp_total_ff;
   logic [23:0] rsp_count_ff;
   logic        rsp_load;

   tally_ctrl_type tally_ctrl;
   logic [47:0]    total_wait;
   logic [23:0]    served_count;

   logic        req_fire;
   logic        issue;
   logic [31:0] n_clamp;
   logic [31:0] arr_wide;
   logic [32:0] next_ext;
   logic [13:0] svc_secs;
   logic [31:0] best_idx_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign issue      = (ptr_ff < n_ff);
   assign arr_wide   = 32'(arr_ff);
   assign svc_secs   = 14'(svc_ff) * SECS_PER_MIN;   // at most 15300
   assign next_ext   = {1'b0, start_ff} + 33'(svc_secs);
   assign best_idx_wide = 32'(best_idx_ff);

   // active_servers of 0 acts as 1, above MAX_SERVERS acts as MAX_SERVERS
   always_comb begin
      if (active_ff == 8'd0) begin
         n_clamp = 32'd1;
      end else if (32'(active_ff) > 32'(MAX_SERVERS)) begin
         n_clamp = 32'(MAX_SERVERS);
      end else begin
         n_clamp = 32'(active_ff);
      end
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= RESET_ACTIVE;
         open_ff   <= RESET_OPEN;
         cutoff_ff <= RESET_CUTOFF;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ACTIVE: active_ff <= csr_wdata[7:0];
            REG_OPEN:   open_ff   <= csr_wdata;
            REG_CUTOFF: cutoff_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      n_in         = n_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = ptr_ff[IDX_W-1:0];
      fill_in      = fill_ff;
      ack_in       = ack_ff;
      arr_in       = arr_ff;
      svc_in       = svc_ff;
      best_time_in = best_time_ff;
      best_idx_in  = best_idx_ff;
      start_in     = start_ff;
      wait_in      = wait_ff;
      acc_in       = acc_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[IDX_W-1:0];
      mem_wdata    = 32'(fill_ff);
      mem_raddr    = ptr_ff[IDX_W-1:0];
      tally_ctrl   = '{clear: 1'b0, add: 1'b0, wait_secs: wait_ff};
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               arr_in      = req_tdata[16:0];
               svc_in      = req_tdata[24:17];
               acc_in      = 1'b0;
               start_in    = '0;
               wait_in     = '0;
               best_idx_in = '0;
               ptr_in      = '0;
               if (req_tuser == OP_RESTART) begin
                  fill_in          = open_ff;
                  ack_in           = 1'b1;
                  tally_ctrl.clear = 1'b1;
                  state_in         = ST_CLEAR;
               end else if (req_tdata[16:0] <= cutoff_ff) begin
                  n_in     = CNT_W'(n_clamp);
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;     // late arrival, rejected
               end
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (ptr_ff == CNT_W'(MAX_SERVERS - 1)) begin
               ptr_in   = '0;
               state_in = ack_ff ? ST_EMIT : ST_IDLE;
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            // read one entry a cycle; data returns the cycle after
            if (issue) begin
               ptr_in     = ptr_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               if (rd_idx_ff == '0 || mem_q_ff < best_time_ff) begin
                  best_time_in = mem_q_ff;
                  best_idx_in  = rd_idx_ff;
               end
            end
            if (!issue && !rd_pend_ff) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (best_time_ff > arr_wide) begin
               start_in = best_time_ff;
               wait_in  = best_time_ff - arr_wide;
            end else begin
               start_in = arr_wide;
               wait_in  = '0;
            end
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // no read of this entry is in flight, so no forwarding is needed
            mem_we         = 1'b1;
            mem_waddr      = best_idx_ff;
            mem_wdata      = next_ext[32] ? TIME_MAX : next_ext[31:0];
            tally_ctrl.add = 1'b1;
            acc_in         = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               ack_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         ptr_ff     <= '0;
         rd_pend_ff <= 1'b0;
         fill_ff    <= RESET_OPEN;
         ack_ff     <= 1'b0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         rd_pend_ff <= rd_pend_in;
         fill_ff    <= fill_in;
         ack_ff     <= ack_in;
         n_ff       <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      arr_ff       <= arr_in;
      svc_ff       <= svc_in;
      best_time_ff <= best_time_in;
      best_idx_ff  <= best_idx_in;
      start_ff     <= start_in;
      wait_ff      <= wait_in;
      acc_ff       <= acc_in;
   end

   // RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= free_mem[mem_raddr];
   end

   efsd_tally u_tally (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (tally_ctrl),
      .total_wait   (total_wait),
      .served_count (served_count)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_acc_ff   <= acc_ff;
         rsp_idx_ff   <= best_idx_wide[6:0];
         rsp_start_ff <= start_ff;
         rsp_wait_ff  <= wait_ff;
         rsp_total_ff <= total_wait;
         rsp_count_ff <= served_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_acc_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_total_ff, rsp_wait_ff,
                        rsp_start_ff, rsp_idx_ff};

   // scan pointer never runs past the server count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> ptr_ff <= n_ff)
      else $error("scan pointer past server count");

   // RAM is written only by the sweep or the commit step
   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_COMMIT))
      else $error("unexpected free-time write");

   // a served job has been counted
   a_served_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[142:119] != 24'd0)
      else $error("served job not counted");

   // a job never waits longer than its start time
   a_wait_le_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[70:39] <= rsp_tdata[38:7])
      else $error("wait exceeds start time");

   // rejects and restart acks carry zero index, start and wait
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[70:0] == 71'd0)
      else $error("non-job result carries job fields");

endmodule

>>> hw/rtl/efsd_tally.sv
// ----------------------------------------------------------------------------
// efsd_tally
// Saturating wait total and served-job count since the last restart.
// ----------------------------------------------------------------------------
module efsd_tally
   import efsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  tally_ctrl_type ctrl,
   output logic [47:0]    total_wait,
   output logic [23:0]    served_count
);

   logic [47:0] sum_ff, sum_in;
   logic [23:0] cnt_ff, cnt_in;
   logic [48:0] sum_ext;

   always_comb begin
      sum_ext = {1'b0, sum_ff} + 49'(ctrl.wait_secs);
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (ctrl.add) begin
         sum_in = (sum_ext > 49'(SUM_MAX)) ? SUM_MAX : sum_ext[47:0];
         if (cnt_ff != CNT_MAX) begin
            cnt_in = cnt_ff + 24'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   assign total_wait   = sum_ff;
   assign served_count = cnt_ff;

endmodule

>>> sim/earliest_free_server_dispatcher_test.sv
// ----------------------------------------------------------------------------
// earliest_free_server_dispatcher_test
// Self-checking bench for the earliest-free-server dispatcher.
// ----------------------------------------------------------------------------
// Jobs and restarts go in on req, one result word per item comes back on rsp.
// A predictor in the bench keeps its own free-time table, totals and csr copy,
// and computes the expected result word whenever a req word is taken. rsp
// words are checked field by field against the oldest outstanding prediction.
// A short hand-written script covers the corners first: cutoff edges, server
// count clamping, ties and the ignored spare csr index. Random phases follow:
// csr writes while idle, then mostly in-order job streams after a restart.
// Both sides idle at random, and the receiver stalls for long stretches so
// that the block backs up into req.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module earliest_free_server_dispatcher_test;
   import efsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SERVERS      = 128;
   localparam int RANDOM_WORDS = 900;
   localparam int LONG_HOLD    = 600;     // receiver hold-off, cycles
   localparam int DRAIN        = 150;     // wait after the last word before the final check
   localparam logic [1:0]  REG_SPARE = 2'd3;  // not a register, write is dropped
   localparam logic [16:0] DAY_LAST  = 17'd86399;
   // slowest run is ~1000 words, each busy for a full scan with the longest
   // gaps on both sides, plus holds, about 3 ms; allow several times that
   localparam longint TIMEOUT_NS = 20_000_000;

   // one result word, split into its fields
   typedef struct packed {
      logic        accepted;
      logic [6:0]  server_index;
      logic [31:0] start_secs;
      logic [31:0] wait_secs;
      logic [47:0] total_wait;
      logic [23:0] served_count;
   } outcome_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic        op;
      logic [16:0] arrival;
      logic [7:0]  service;
      logic [1:0]  addr;
      logic [16:0] value;
      bit          typed;     // want below is hand-written
      outcome_type want;
   } row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_addr = '0;
   logic [16:0]   csr_wdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;     // arrival_seconds[16:0], service_minutes[24:17]
   logic          req_tuser = 1'b0;   // op
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [143:0]  rsp_tdata;          // server_index[6:0], start_seconds[38:7],
                                      // wait_seconds[70:39], total_wait[118:71],
                                      // served_count[142:119]
   logic          rsp_tuser;          // accepted

   earliest_free_server_dispatcher #(.MAX_SERVERS(SERVERS)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor state: free-time table, totals and the csr copy
   // ---------------------------------------------------------------------
   logic [31:0] free_time [SERVERS];
   logic [47:0] wait_total;
   logic [23:0] job_tally;
   logic [7:0]  cfg_active;
   logic [16:0] cfg_open;
   logic [16:0] cfg_cutoff;

   outcome_type pending [$];    // predicted rsp words, oldest first
   row_type     script [$];     // directed rows, in order
   int       mismatches = 0;
   int       words_sent = 0;
   bit       steady = 0;        // sender runs without gaps this phase
   bit       csr_pending = 0;   // csr_we left high by the last write
   bit       rsp_hold_pending = 0;

   // Result word for one req word; updates the predictor state as the
   // block would.
   function automatic outcome_type dispatch_outcome(input logic op,
                                                    input logic [16:0] arrival,
                                                    input logic [7:0] service);
      outcome_type o;
      int          n;
      int          best;
      logic [40:0] free_next;
      logic [48:0] sum;
      o = '0;
      if (op == OP_RESTART) begin
         // restart refills every entry, not only the active ones
         foreach (free_time[i]) free_time[i] = {15'd0, cfg_open};
         wait_total = '0;
         job_tally  = '0;
      end else if (arrival <= cfg_cutoff) begin
         n = cfg_active;
         if (n < 1) n = 1;
         if (n > SERVERS) n = SERVERS;
         best = 0;
         for (int j = 1; j < n; j++)
            if (free_time[j] < free_time[best]) best = j;
         if (free_time[best] > {15'd0, arrival}) begin
            o.start_secs = free_time[best];
            o.wait_secs  = free_time[best] - {15'd0, arrival};
         end else begin
            o.start_secs = {15'd0, arrival};
            o.wait_secs  = '0;
         end
         free_next = 41'(o.start_secs) + 41'(service) * 41'(SECS_PER_MIN);
         free_time[best] = (free_next > 41'(TIME_MAX)) ? TIME_MAX : free_next[31:0];
         sum = 49'(wait_total) + 49'(o.wait_secs);
         wait_total = (sum > 49'(SUM_MAX)) ? SUM_MAX : sum[47:0];
         if (job_tally != CNT_MAX) job_tally = job_tally + 24'd1;
         o.accepted     = 1'b1;
         o.server_index = best[6:0];
      end
      o.total_wait   = wait_total;
      o.served_count = job_tally;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly a handful of servers; now and then zero, full and over-range
   function automatic logic [16:0] pick_active();
      int r;
      r = $urandom_range(0, 19);
      if (r < 8)   return 17'($urandom_range(1, 4));
      if (r < 14)  return 17'($urandom_range(5, 16));
      if (r < 16)  return 17'($urandom_range(17, 127));
      if (r == 16) return 17'd0;
      if (r == 17) return 17'd128;
      // junk in the upper wdata bits must not matter
      return {9'($urandom), 8'($urandom_range(129, 255))};
   endfunction

   function automatic logic [7:0] pick_service();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 8'($urandom_range(1, 30));
      if (r < 9) return 8'($urandom_range(0, 255));
      return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
   endfunction

   function automatic outcome_type outcome(input logic acc, input int idx,
                                           input logic [31:0] st,
                                           input logic [31:0] wt,
                                           input logic [47:0] tot,
                                           input logic [23:0] cnt);
      outcome_type o;
      o.accepted     = acc;
      o.server_index = idx[6:0];
      o.start_secs   = st;
      o.wait_secs    = wt;
      o.total_wait   = tot;
      o.served_count = cnt;
      return o;
   endfunction

   function automatic row_type word_row(input logic op, input logic [16:0] arrival,
                                        input logic [7:0] service,
                                        input bit typed = 0,
                                        input outcome_type want = '0);
      row_type w;
      w = '{kind: ROW_WORD, op: op, arrival: arrival, service: service,
            addr: '0, value: '0, typed: typed, want: want};
      return w;
   endfunction

   function automatic row_type csr_row(input logic [1:0] addr, input logic [16:0] value);
      row_type w;
      w = '{kind: ROW_CSR, op: OP_JOB, arrival: '0, service: '0,
            addr: addr, value: value, typed: 0, want: '0};
      return w;
   endfunction

   // append one row to the directed script
   function automatic void add_row(input row_type w);
      script = {script, w};
   endfunction

   // Drive one req word and wait for it to be taken. Called at a rising edge;
   // returns at the edge that took the word with tvalid still high, so the
   // next word can follow back to back.
   task automatic send_word(input logic op, input logic [16:0] arrival,
                            input logic [7:0] service, input bit typed = 0,
                            input outcome_type want = '0);
      int          gap;
      outcome_type predicted;
      if (csr_pending) begin
         csr_we <= 1'b0;
         csr_pending = 0;
      end
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, service, arrival};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = dispatch_outcome(op, arrival, service);
      pending = {pending, (typed ? want : predicted)};
      words_sent++;
   endtask

   // drop tvalid and wait until every predicted word has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   // one csr write per edge; the predictor copy follows right away
   task automatic csr_write(input logic [1:0] addr, input logic [16:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      csr_pending = 1;
      case (addr)
         REG_ACTIVE: cfg_active = value[7:0];
         REG_OPEN:   cfg_open   = value;
         REG_CUTOFF: cfg_cutoff = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // rsp side: pacing and checking
   // ---------------------------------------------------------------------
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_pending) begin
            // long hold-off; the sender keeps offering so req backs up
            rsp_hold_pending = 0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat (1 + pick_gap()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      outcome_type got;
      outcome_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.accepted     = rsp_tuser;
            got.server_index = rsp_tdata[6:0];
            got.start_secs   = rsp_tdata[38:7];
            got.wait_secs    = rsp_tdata[70:39];
            got.total_wait   = rsp_tdata[118:71];
            got.served_count = rsp_tdata[142:119];
            if (pending.size() == 0) begin
               report_mismatch("rsp word with nothing outstanding", 0, 0);
            end else begin
               want = pending.pop_front();
               if (got.accepted != want.accepted)
                  report_mismatch("accepted", got.accepted, want.accepted);
               if (got.server_index != want.server_index)
                  report_mismatch("server_index", got.server_index, want.server_index);
               if (got.start_secs != want.start_secs)
                  report_mismatch("start_seconds", got.start_secs, want.start_secs);
               if (got.wait_secs != want.wait_secs)
                  report_mismatch("wait_seconds", got.wait_secs, want.wait_secs);
               if (got.total_wait != want.total_wait)
                  report_mismatch("total_wait", got.total_wait, want.total_wait);
               if (got.served_count != want.served_count)
                  report_mismatch("served_count", got.served_count, want.served_count);
            end
         end
      end
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("earliest_free_server_dispatcher regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence: reset, directed script, random phases, drain
   // ---------------------------------------------------------------------
   initial begin
      int    phase;
      int    jobs;
      int    r;
      int    t;
      logic [16:0] v;

      // predictor at reset: all entries at the reset open time
      foreach (free_time[i]) free_time[i] = {15'd0, RESET_OPEN};
      wait_total = '0;
      job_tally  = '0;
      cfg_active = RESET_ACTIVE;
      cfg_open   = RESET_OPEN;
      cfg_cutoff = RESET_CUTOFF;

      // Directed script. Rows with a typed result are read straight off the
      // rules; the rest are left to the predictor.
      // reset settings: one server, open 28800, cutoff 61200
      add_row(word_row(OP_JOB, 17'd0, 8'd0, 1,
                       outcome(1, 0, 28800, 28800, 28800, 1)));
      // arrival exactly at cutoff still served
      add_row(word_row(OP_JOB, 17'd61200, 8'd255, 1,
                       outcome(1, 0, 61200, 0, 28800, 2)));
      // one second late: rejected, totals unchanged
      add_row(word_row(OP_JOB, 17'd61201, 8'd1, 1,
                       outcome(0, 0, 0, 0, 28800, 2)));
      add_row(word_row(OP_JOB, DAY_LAST, 8'd255, 1,
                       outcome(0, 0, 0, 0, 28800, 2)));
      add_row(word_row(OP_RESTART, 17'd0, 8'd0, 1, '0));
      // zero servers acts as one; open at midnight, cutoff at end of day
      add_row(csr_row(REG_ACTIVE, 17'd0));
      add_row(csr_row(REG_OPEN, 17'd0));
      add_row(csr_row(REG_CUTOFF, DAY_LAST));
      add_row(csr_row(REG_SPARE, 17'h1FFFF));
      add_row(word_row(OP_RESTART, DAY_LAST, 8'd255, 1, '0));
      add_row(word_row(OP_JOB, 17'd0, 8'd255, 1,
                       outcome(1, 0, 0, 0, 0, 1)));
      add_row(word_row(OP_JOB, 17'd100, 8'd0, 1,
                       outcome(1, 0, 15300, 15200, 15200, 2)));
      add_row(word_row(OP_JOB, DAY_LAST, 8'd0, 1,
                       outcome(1, 0, 86399, 0, 15200, 3)));
      // 255 clamps to all servers; open at the last second, cutoff zero
      add_row(csr_row(REG_ACTIVE, 17'd255));
      add_row(csr_row(REG_OPEN, DAY_LAST));
      add_row(csr_row(REG_CUTOFF, 17'd0));
      add_row(word_row(OP_RESTART, 17'd0, 8'd0, 1, '0));
      // all tied: lowest index first, then the next one
      add_row(word_row(OP_JOB, 17'd0, 8'd1, 1,
                       outcome(1, 0, 86399, 86399, 86399, 1)));
      add_row(word_row(OP_JOB, 17'd0, 8'd1, 1,
                       outcome(1, 1, 86399, 86399, 172798, 2)));
      add_row(word_row(OP_JOB, 17'd1, 8'd0, 1,
                       outcome(0, 0, 0, 0, 172798, 2)));
      // 129 with junk in the upper bits clamps to 128
      add_row(csr_row(REG_ACTIVE, 17'h1FF81));
      add_row(csr_row(REG_OPEN, 17'd100));
      add_row(csr_row(REG_CUTOFF, DAY_LAST));
      add_row(word_row(OP_RESTART, 17'd0, 8'd0, 1, '0));
      add_row(word_row(OP_JOB, 17'd100, 8'd1));
      add_row(word_row(OP_JOB, 17'd50, 8'd2));    // out of order
      // shrink to three servers without a restart; old free times stay
      add_row(csr_row(REG_ACTIVE, 17'd3));
      add_row(csr_row(REG_OPEN, 17'd28800));
      add_row(csr_row(REG_CUTOFF, 17'd61200));
      add_row(word_row(OP_JOB, 17'd28800, 8'd10));
      add_row(word_row(OP_RESTART, 17'd0, 8'd0, 1, '0));
      // four jobs on three servers: the fourth queues behind server 0
      repeat (4) add_row(word_row(OP_JOB, 17'd28800, 8'd10));
      add_row(word_row(OP_JOB, 17'd29000, 8'd5));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // the block sweeps its table after reset; send_word waits on tready
      foreach (script[k]) begin
         if (script[k].kind == ROW_CSR) begin
            if (!csr_pending) settle();
            csr_write(script[k].addr, script[k].value);
         end else begin
            send_word(script[k].op, script[k].arrival, script[k].service,
                      script[k].typed, script[k].want);
         end
      end

      // Random phases: new settings while idle, usually a restart, then an
      // in-order stream of jobs around the open time with some noise.
      phase = 0;
      while (words_sent < script.size() + RANDOM_WORDS) begin
         settle();
         steady = ($urandom_range(0, 3) == 0);
         if (phase == 3 || phase == 14) begin
            steady = 1;
            rsp_hold_pending = 1;
         end
         if ($urandom_range(0, 2) != 0) csr_write(REG_ACTIVE, pick_active());
         if ($urandom_range(0, 2) != 0)
            csr_write(REG_OPEN, 17'($urandom_range(0, 86399)));
         if ($urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 9) < 7)
               v = 17'($urandom_range(86399, cfg_open));
            else
               v = 17'($urandom_range(0, 86399));
            csr_write(REG_CUTOFF, v);
         end
         if ($urandom_range(0, 9) == 0) csr_write(REG_SPARE, 17'($urandom));
         if ($urandom_range(0, 19) != 0)
            send_word(OP_RESTART, 17'($urandom_range(0, 86399)), 8'($urandom));

         t = (cfg_open > 1800) ? int'(cfg_open) - $urandom_range(0, 1800) : 0;
         jobs = $urandom_range(8, 40);
         repeat (jobs) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               send_word(OP_RESTART, 17'($urandom_range(0, 86399)), 8'($urandom));
            end else if (r < 10) begin
               // arrival anywhere in the day, order broken
               send_word(OP_JOB, 17'($urandom_range(0, 86399)), pick_service());
            end else begin
               t = t + (($urandom_range(0, 4) == 0) ? $urandom_range(600, 3000)
                                                   : $urandom_range(0, 300));
               if (t > 86399) t = 86399;
               send_word(OP_JOB, 17'(t), pick_service());
            end
         end
         phase++;
      end

      settle();
      steady = 0;
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0 && pending.size() == 0) begin
         $display("earliest_free_server_dispatcher regression: pass");
      end else begin
         $display("earliest_free_server_dispatcher regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/efsd_pkg.sv
hw/rtl/efsd_tally.sv
hw/rtl/earliest_free_server_dispatcher.sv
sim/earliest_free_server_dispatcher_test.sv
